// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the datapath and controller rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

// ===== hw/rtl/ffbc_pkg.sv =====
// constants and controller/datapath interface types for the flux balance block
// no dependencies
`default_nettype none

package ffbc_pkg;

  localparam int MAX_FACES  = 64;
  localparam int FLUX_WIDTH = 32;
  localparam int ADDR_W     = $clog2(MAX_FACES);
  localparam int CNT_W      = $clog2(MAX_FACES + 1);
  localparam int SUM_W      = FLUX_WIDTH + ADDR_W;
  localparam int FRAC_W     = 16;
  localparam int FACTOR_W   = FRAC_W + 1;
  localparam int STEP_W     = $clog2(FRAC_W + 1);
  localparam int THR_W      = 16;
  localparam int PROD_W     = FLUX_WIDTH + FRAC_W;

  localparam logic [FACTOR_W-1:0] UNITY = FACTOR_W'(1) << FRAC_W;

  typedef struct packed {
    logic load_face;
    logic setup;
    logic div_step;
    logic emit_load;
    logic emit_next;
    logic clear_set;
  } ffbc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_idx;
  } ffbc_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ffbc_datapath.sv =====
// face store, inflow/outflow totals, serial divider and scaling multiplier
// depends on ffbc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ffbc_datapath import ffbc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire ffbc_cmd_t              cmd,
  output ffbc_status_t                status,
  input  wire logic                   cfg_write,
  input  wire logic [THR_W-1:0]       cfg_threshold,
  input  wire logic signed [FLUX_WIDTH-1:0] face_flux,
  input  wire logic                   face_flipped,
  input  wire logic                   face_internal,
  output logic signed [FLUX_WIDTH-1:0] corrected_flux,
  output logic [ADDR_W-1:0]           face_position,
  output logic [FACTOR_W-1:0]         correction_factor,
  output logic                        face_scaled,
  output logic                        last_result
);

  logic [FLUX_WIDTH+1:0] face_mem [MAX_FACES];
  logic [FLUX_WIDTH+1:0] rd_data;

  logic [THR_W-1:0]    threshold;
  logic [CNT_W-1:0]    face_count;
  logic [SUM_W-1:0]    inflow_sum;
  logic [SUM_W-1:0]    outflow_sum;
  logic [ADDR_W-1:0]   idx;
  logic [ADDR_W-1:0]   idx_next;
  logic                scaling;
  logic                scale_in;
  logic [SUM_W-1:0]    larger;
  logic [SUM_W-1:0]    rem;
  logic [FACTOR_W-1:0] factor;
  logic [STEP_W-1:0]   div_cnt;

  logic                  in_neg;
  logic [FLUX_WIDTH-1:0] in_mag;
  logic                  in_inflow;
  logic                  store_ok;

  logic                  in_gt;
  logic [SUM_W-1:0]      imb;
  logic                  imb_over;

  logic [SUM_W:0]        rem_shift;
  logic                  rem_ge;

  logic [FLUX_WIDTH-1:0] rd_flux;
  logic                  rd_flip;
  logic                  rd_internal;
  logic                  rd_neg;
  logic [FLUX_WIDTH-1:0] rd_mag;
  logic [PROD_W-1:0]     prod;
  logic [FLUX_WIDTH-1:0] scaled_mag;
  logic [FLUX_WIDTH-1:0] scaled_flux;
  logic                  do_scale;

  // input side
  assign in_neg    = face_flux[FLUX_WIDTH-1];
  assign in_mag    = in_neg ? (~face_flux + 1'b1) : face_flux;
  assign in_inflow = face_flipped ^ in_neg;
  assign store_ok  = face_count < CNT_W'(MAX_FACES);

  // imbalance check
  assign in_gt    = inflow_sum > outflow_sum;
  assign imb      = in_gt ? (inflow_sum - outflow_sum) : (outflow_sum - inflow_sum);
  assign imb_over = imb > SUM_W'(threshold);

  // restoring divider step
  assign rem_shift = {rem, 1'b0};
  assign rem_ge    = rem_shift >= {1'b0, larger};

  // emit side
  assign rd_flux     = rd_data[FLUX_WIDTH-1:0];
  assign rd_flip     = rd_data[FLUX_WIDTH];
  assign rd_internal = rd_data[FLUX_WIDTH+1];
  assign rd_neg      = rd_flux[FLUX_WIDTH-1];
  assign rd_mag      = rd_neg ? (~rd_flux + 1'b1) : rd_flux;
  assign prod        = PROD_W'(rd_mag) * PROD_W'(factor[FRAC_W-1:0]);
  assign scaled_mag  = prod[PROD_W-1:FRAC_W];
  assign scaled_flux = rd_neg ? (~scaled_mag + 1'b1) : scaled_mag;
  assign do_scale    = scaling && rd_internal && ((rd_flip ^ rd_neg) == scale_in);

  always_comb begin
    priority if (cmd.setup) begin
      idx_next = '0;
    end else if (cmd.emit_next) begin
      idx_next = idx + 1'b1;
    end else begin
      idx_next = idx;
    end
  end

  assign status.div_done = (div_cnt == '0);
  assign status.last_idx = (CNT_W'(idx) + 1'b1) == face_count;

  // face store
  always_ff @(posedge clk) begin
    if (cmd.load_face && store_ok) begin
      face_mem[face_count[ADDR_W-1:0]] <= {face_internal, face_flipped, face_flux};
    end
    rd_data <= face_mem[idx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= '0;
      face_count  <= '0;
      inflow_sum  <= '0;
      outflow_sum <= '0;
      div_cnt     <= '0;
      idx         <= '0;
    end else begin
      idx <= idx_next;
      if (cfg_write) begin
        threshold <= cfg_threshold;
      end
      if (cmd.clear_set) begin
        face_count  <= '0;
        inflow_sum  <= '0;
        outflow_sum <= '0;
      end else if (cmd.load_face && store_ok) begin
        face_count <= face_count + 1'b1;
        if (in_inflow) begin
          inflow_sum <= inflow_sum + SUM_W'(in_mag);
        end else begin
          outflow_sum <= outflow_sum + SUM_W'(in_mag);
        end
      end
      if (cmd.setup) begin
        div_cnt <= imb_over ? STEP_W'(FRAC_W) : '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt - 1'b1;
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      scaling  <= imb_over;
      scale_in <= in_gt;
      larger   <= in_gt ? inflow_sum : outflow_sum;
      rem      <= in_gt ? outflow_sum : inflow_sum;
      factor   <= imb_over ? '0 : UNITY;
    end else if (cmd.div_step) begin
      rem    <= rem_ge ? SUM_W'(rem_shift - {1'b0, larger}) : rem_shift[SUM_W-1:0];
      factor <= {factor[FACTOR_W-2:0], rem_ge};
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      corrected_flux    <= do_scale ? scaled_flux : rd_flux;
      face_position     <= idx;
      correction_factor <= factor;
      face_scaled       <= do_scale;
      last_result       <= status.last_idx;
    end
  end

  `ASSERT_CLK(a_count_max, clk, rst, face_count <= CNT_W'(MAX_FACES), "face count past store depth")
  `ASSERT_CLK(a_rem_below, clk, rst, (div_cnt != '0) |-> (rem < larger), "divider remainder not below divisor")
  `ASSERT_CLK(a_emit_stored, clk, rst, cmd.emit_load |-> (CNT_W'(idx) < face_count), "emit index past stored faces")
  `ASSERT_CLK(a_unity_idle, clk, rst, (cmd.emit_load && !scaling) |-> (factor == UNITY), "factor not unity without scaling")

endmodule

`default_nettype wire

// ===== hw/rtl/ffbc_ctrl.sv =====
// state machine sequencing load, divide and emit phases
// depends on ffbc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ffbc_ctrl import ffbc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic         last_face,
  output logic              in_stall,
  output logic              out_valid,
  input  wire logic         out_stall,
  output ffbc_cmd_t         cmd,
  input  wire ffbc_status_t status
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_face = 1'b1;
          if (last_face) begin
            state_next = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_LOAD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_LOAD: begin
        cmd.emit_load = 1'b1;
        state_next    = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          if (status.last_idx) begin
            cmd.clear_set = 1'b1;
            state_next    = ST_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_next    = ST_LOAD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `ASSERT_NEVER(a_no_overlap, clk, rst, out_valid && !in_stall, "input open while word pending")
  `ASSERT_CLK(a_div_after_setup, clk, rst, cmd.setup |=> (state == ST_DIV), "setup not followed by divide")

endmodule

`default_nettype wire

// ===== hw/rtl/face_flux_balance_correction.sv =====
// top level of the face flux balance correction block
// depends on ffbc_pkg, ffbc_ctrl and ffbc_datapath
`default_nettype none

// Faces are taken one per cycle while in_stall is low and held in a 64-entry
// store; faces beyond 64 are dropped. The face flagged last_face closes the set:
// in_stall then rises, the imbalance is checked against the threshold and,
// when scaling applies, a one-bit-per-cycle divider forms the Q1.16 factor.
// Every stored face is then sent in load order through the store read
// register, then the scaling multiplier into the output register; the next word
// starts only once the current one is taken. in_stall falls once the word with
// last_result is taken. The threshold register accepts a write in any cycle.

module face_flux_balance_correction import ffbc_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [THR_W-1:0]              imbalance_threshold,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [FLUX_WIDTH-1:0]  face_flux,
  input  wire logic                          face_flipped,
  input  wire logic                          face_internal,
  input  wire logic                          last_face,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [FLUX_WIDTH-1:0]       corrected_flux,
  output logic [ADDR_W-1:0]                  face_position,
  output logic [FACTOR_W-1:0]                correction_factor,
  output logic                               face_scaled,
  output logic                               last_result
);

  ffbc_cmd_t    cmd;
  ffbc_status_t status;

  assign cfg_ready = 1'b1;

  ffbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_face (last_face),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  ffbc_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .cfg_write         (cfg_valid && cfg_ready),
    .cfg_threshold     (imbalance_threshold),
    .face_flux         (face_flux),
    .face_flipped      (face_flipped),
    .face_internal     (face_internal),
    .corrected_flux    (corrected_flux),
    .face_position     (face_position),
    .correction_factor (correction_factor),
    .face_scaled       (face_scaled),
    .last_result       (last_result)
  );

endmodule

`default_nettype wire

// ===== tb/tb_face_flux_balance_correction.sv =====
`timescale 1ns / 100ps
// self-checking testbench for face_flux_balance_correction: drives face sets, predicts
// every corrected word and compares each word the block sends against that prediction
// depends on ffbc_pkg and the rtl of the block

module tb_face_flux_balance_correction;
  import ffbc_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [FLUX_WIDTH-1:0] flux;
    logic [ADDR_W-1:0]     position;
    logic [FACTOR_W-1:0]   factor;
    logic                  scaled;
    logic                  last;
  } corr_word_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [THR_W-1:0]             imbalance_threshold = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [FLUX_WIDTH-1:0] face_flux = '0;
  logic                         face_flipped = 1'b0;
  logic                         face_internal = 1'b0;
  logic                         last_face = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [FLUX_WIDTH-1:0] corrected_flux;
  logic [ADDR_W-1:0]            face_position;
  logic [FACTOR_W-1:0]          correction_factor;
  logic                         face_scaled;
  logic                         last_result;

  // model of the face store and running totals
  logic [FLUX_WIDTH-1:0] set_flux [MAX_FACES];
  logic                  set_flipped [MAX_FACES];
  logic                  set_internal [MAX_FACES];
  int                    set_count = 0;
  longint                inflow_total = 0;
  longint                outflow_total = 0;
  logic [THR_W-1:0]      threshold_now = '0;

  corr_word_t pending_words[$];
  int         mismatches = 0;
  bit         send_gaps = 1'b1;
  bit         stall_gaps = 1'b1;
  int         stall_left = 0;
  int         quiet_cycles = 0;

  face_flux_balance_correction uut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .imbalance_threshold (imbalance_threshold),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .face_flux           (face_flux),
    .face_flipped        (face_flipped),
    .face_internal       (face_internal),
    .last_face           (last_face),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .corrected_flux      (corrected_flux),
    .face_position       (face_position),
    .correction_factor   (correction_factor),
    .face_scaled         (face_scaled),
    .last_result         (last_result)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic bit on_inflow(logic [FLUX_WIDTH-1:0] flux, logic flipped);
    return flipped ? !flux[FLUX_WIDTH-1] : flux[FLUX_WIDTH-1];
  endfunction

  function automatic longint flux_magnitude(logic [FLUX_WIDTH-1:0] flux);
    longint v;
    v = longint'($signed(flux));
    return (v < 0) ? -v : v;
  endfunction

  task automatic balance_face(logic [FLUX_WIDTH-1:0] flux, logic flipped, logic internal,
                              logic last);
    longint     imbalance;
    longint     factor;
    longint     scaled_mag;
    bit         scaling;
    bit         scale_inflow;
    bit         hit;
    corr_word_t w;
    if (set_count < MAX_FACES) begin
      set_flux[set_count] = flux;
      set_flipped[set_count] = flipped;
      set_internal[set_count] = internal;
      set_count++;
      if (on_inflow(flux, flipped))
        inflow_total += flux_magnitude(flux);
      else
        outflow_total += flux_magnitude(flux);
    end
    if (!last)
      return;
    factor = longint'(UNITY);
    scaling = 1'b0;
    scale_inflow = 1'b0;
    imbalance = inflow_total - outflow_total;
    if (imbalance < 0)
      imbalance = -imbalance;
    if (imbalance > longint'(threshold_now)) begin
      scaling = 1'b1;
      scale_inflow = inflow_total > outflow_total;
      if (scale_inflow)
        factor = (outflow_total << FRAC_W) / inflow_total;
      else
        factor = (inflow_total << FRAC_W) / outflow_total;
    end
    for (int i = 0; i < set_count; i++) begin
      hit = scaling && set_internal[i] &&
            (on_inflow(set_flux[i], set_flipped[i]) == scale_inflow);
      w.flux = set_flux[i];
      if (hit) begin
        scaled_mag = (flux_magnitude(set_flux[i]) * factor) >> FRAC_W;
        w.flux = set_flux[i][FLUX_WIDTH-1] ? FLUX_WIDTH'(-scaled_mag)
                                           : FLUX_WIDTH'(scaled_mag);
      end
      w.position = ADDR_W'(i);
      w.factor = FACTOR_W'(factor);
      w.scaled = hit;
      w.last = (i == set_count - 1);
      pending_words.push_back(w);
    end
    set_count = 0;
    inflow_total = 0;
    outflow_total = 0;
  endtask

  task automatic send_face(logic [FLUX_WIDTH-1:0] flux, logic flipped, logic internal,
                           logic last);
    int gap;
    gap = send_gaps ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    face_flux <= flux;
    face_flipped <= flipped;
    face_internal <= internal;
    last_face <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    balance_face(flux, flipped, internal, last);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] value);
    cfg_valid <= 1'b1;
    imbalance_threshold <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    threshold_now = value;
  endtask

  // block is idle once every word is back and the pipeline has had time to empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [FLUX_WIDTH-1:0] pick_flux();
    logic [FLUX_WIDTH-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2, 3, 4: begin
        v = $urandom_range(0, 1 << 17);
        if ($urandom_range(0, 1))
          v = -v;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: v = {1'b0, {(FLUX_WIDTH-1){1'b1}}};
          1: v = {1'b1, {(FLUX_WIDTH-1){1'b0}}};
          2: v = '0;
          default: v = '1;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_set(int faces);
    for (int i = 0; i < faces; i++)
      send_face(pick_flux(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                i == faces - 1);
  endtask

  task automatic check_field(string name, logic signed [63:0] expected_v,
                             logic signed [63:0] actual_v);
    if (expected_v !== actual_v) begin
      $error("%s: expected %0d, got %0d", name, expected_v, actual_v);
      mismatches++;
    end
  endtask

  task automatic test_field_extremes();
    write_threshold('0);
    send_face({1'b0, {(FLUX_WIDTH-1){1'b1}}}, 1'b0, 1'b1, 1'b0);
    send_face({1'b1, {(FLUX_WIDTH-1){1'b0}}}, 1'b1, 1'b1, 1'b0);
    send_face('0, 1'b0, 1'b0, 1'b0);
    send_face('1, 1'b1, 1'b0, 1'b0);
    send_face(1, 1'b0, 1'b1, 1'b1);
    settle();
  endtask

  task automatic test_balanced_set();
    send_face(5000, 1'b0, 1'b1, 1'b0);
    send_face(-5000, 1'b0, 1'b1, 1'b0);
    send_face('0, 1'b1, 1'b1, 1'b1);
    settle();
  endtask

  // imbalance equal to the threshold is left alone, one above it is corrected
  task automatic test_threshold_edge();
    write_threshold('1);
    send_face(66535, 1'b0, 1'b1, 1'b0);
    send_face(-1000, 1'b0, 1'b1, 1'b1);
    send_face(66536, 1'b0, 1'b1, 1'b0);
    send_face(-1000, 1'b0, 1'b1, 1'b1);
    settle();
  endtask

  task automatic test_single_face_sets();
    write_threshold(THR_W'(100));
    send_face(12345, 1'b0, 1'b1, 1'b1);
    send_face(-7, 1'b1, 1'b0, 1'b1);
    settle();
  endtask

  task automatic test_store_overflow();
    write_threshold(THR_W'($urandom_range(0, (1 << THR_W) - 1)));
    send_set(MAX_FACES + 3);
    settle();
  endtask

  task automatic test_random_sets();
    int sent;
    int faces;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_threshold('0);
        1: write_threshold('1);
        2: write_threshold(THR_W'($urandom_range(0, 255)));
        default: write_threshold(THR_W'($urandom_range(0, (1 << THR_W) - 1)));
      endcase
      send_gaps = (phase != 1) && (phase != 3);
      stall_gaps = (phase != 1) && (phase != 2);
      sent = 0;
      while (sent < 16) begin
        if ($urandom_range(0, 7) == 0)
          faces = $urandom_range(9, 40);
        else
          faces = $urandom_range(1, 8);
        send_set(faces);
        sent += faces;
      end
      settle();
    end
    send_gaps = 1'b1;
    stall_gaps = 1'b1;
  endtask

  always @(posedge clk) begin
    corr_word_t w;
    if (rst) begin
      stall_left = 0;
    end else if (out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("word with no prediction at face_position %0d", face_position);
        mismatches++;
      end else begin
        w = pending_words.pop_front();
        check_field("corrected_flux", 64'($signed(w.flux)), 64'(corrected_flux));
        check_field("face_position", 64'(w.position), 64'(face_position));
        check_field("correction_factor", 64'(w.factor), 64'(correction_factor));
        check_field("face_scaled", 64'(w.scaled), 64'(face_scaled));
        check_field("last_result", 64'(w.last), 64'(last_result));
      end
      stall_left = stall_gaps ? $urandom_range(0, 4) : 0;
      out_stall <= (stall_left != 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_field_extremes();
    test_balanced_set();
    test_threshold_edge();
    test_single_face_sets();
    test_store_overflow();
    test_random_sets();
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
